// ===== rtl/nfrc_pkg.sv =====
package nfrc_pkg;

    localparam int ITERATIONS = 30;
    localparam int FRAC_BITS  = 28;
    localparam int QW         = 48;
    localparam int FB         = 32;
    localparam int IN_SHIFT   = 32 - FRAC_BITS;
    localparam int DIV_STEPS  = QW - 1;
    localparam int DIV_PRE    = QW - 1 - FB;
    localparam int NROOTS     = 8;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam t_q QONE = 48'sh0001_0000_0000;
    localparam t_q QFOUR = 48'sh0004_0000_0000;

    localparam t_q ROOT_RE [NROOTS] = '{QONE, -QONE, QONE, QONE, '0, '0, -QONE, -QONE};
    localparam t_q ROOT_IM [NROOTS] = '{'0, '0, QONE, -QONE, QONE, -QONE, QONE, -QONE};

    typedef struct packed {
        t_q re;
        t_q im;
    } t_cplx;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } t_in;

    typedef struct packed {
        logic [2:0]         root_index;
        logic signed [31:0] z_re;
        logic signed [31:0] z_im;
        logic               div_zero;
    } t_out;

    // Partial products of one magnitude multiply, split at bit 32.
    typedef struct packed {
        logic        neg;
        logic [31:0] hh;
        logic [47:0] hl;
        logic [47:0] lh;
        logic [31:0] ll;
    } t_mpp;

    typedef struct packed {
        t_mpp rr;
        t_mpp ii;
        t_mpp ri;
        t_mpp ir;
    } t_cpp;

    // State carried alongside a division.
    typedef struct packed {
        t_cplx z;
        t_cplx p;
        t_cplx d;
        logic  br;
        logic  dz;
        logic  flag;
    } t_side;

    function automatic t_q qsat(input logic signed [63:0] v);
        if (v > 64'(QMAX)) begin
            return QMAX;
        end else if (v < 64'(QMIN)) begin
            return QMIN;
        end
        return QW'(v);
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        return qsat(64'(a) + 64'(b));
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        return qsat(64'(a) - 64'(b));
    endfunction

    function automatic t_q qscale(input t_q a, input logic [3:0] k);
        return qsat(64'(a) * $signed({60'd0, k}));
    endfunction

    function automatic t_cplx cscale(input t_cplx a, input logic [3:0] k);
        t_cplx r;
        r.re = qscale(a.re, k);
        r.im = qscale(a.im, k);
        return r;
    endfunction

    function automatic logic [QW:0] qabs(input t_q a);
        logic signed [QW:0] e;
        e = (QW+1)'(a);
        return a[QW-1] ? -e : e;
    endfunction

    function automatic logic [QW-1:0] qmag(input t_q a);
        return a[QW-1] ? -a : a;
    endfunction

    function automatic t_q qsigned(input logic [63:0] mag, input logic neg);
        if (neg) begin
            return (mag >= 64'h0000_8000_0000_0000) ? QMIN : t_q'(-mag[QW-1:0]);
        end
        return (mag > 64'h0000_7FFF_FFFF_FFFF) ? QMAX : t_q'(mag[QW-1:0]);
    endfunction

    function automatic t_mpp mul_pp(input t_q a, input t_q b);
        t_mpp        m;
        logic [47:0] ma;
        logic [47:0] mb;
        logic [63:0] low;
        ma    = qmag(a);
        mb    = qmag(b);
        m.neg = a[QW-1] ^ b[QW-1];
        m.hh  = 32'(ma[47:32]) * 32'(mb[47:32]);
        m.hl  = 48'(ma[47:32]) * 48'(mb[31:0]);
        m.lh  = 48'(ma[31:0]) * 48'(mb[47:32]);
        low   = 64'(ma[31:0]) * 64'(mb[31:0]);
        m.ll  = low[63:32];
        return m;
    endfunction

    function automatic t_q mul_fin(input t_mpp m);
        logic [63:0] s;
        s = {m.hh, 32'd0} + 64'(m.hl) + 64'(m.lh) + 64'(m.ll);
        return qsigned(s, m.neg);
    endfunction

    function automatic t_cpp cmul_pp(input t_cplx a, input t_cplx b);
        t_cpp c;
        c.rr = mul_pp(a.re, b.re);
        c.ii = mul_pp(a.im, b.im);
        c.ri = mul_pp(a.re, b.im);
        c.ir = mul_pp(a.im, b.re);
        return c;
    endfunction

    function automatic t_cplx cmul_fin(input t_cpp c);
        t_cplx r;
        r.re = qsub(mul_fin(c.rr), mul_fin(c.ii));
        r.im = qadd(mul_fin(c.ri), mul_fin(c.ir));
        return r;
    endfunction

    function automatic logic signed [31:0] to_out(input t_q v);
        t_q s;
        s = v >>> IN_SHIFT;
        if (s > t_q'(48'sh0000_7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (s < t_q'(-48'sh0000_8000_0000)) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic t_q from_in(input logic signed [31:0] c);
        t_q e;
        e = QW'(c);
        return e <<< IN_SHIFT;
    endfunction

endpackage

// ===== rtl/nfrc_div.sv =====
module nfrc_div
    import nfrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_q    i_a,
    input  t_q    i_b,
    input  t_side i_side,
    output logic  o_vld,
    output t_q    o_q,
    output t_side o_side
);

    // Restoring division of |a| * 2^32 by |b|, one quotient bit per stage.
    logic [DIV_STEPS:0]   r_v;
    logic [QW-1:0]        r_ma   [0:DIV_STEPS];
    logic [QW-1:0]        r_mb   [0:DIV_STEPS];
    logic [QW-1:0]        r_rem  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q    [0:DIV_STEPS];
    logic                 r_neg  [0:DIV_STEPS];
    logic                 r_ovf  [0:DIV_STEPS];
    t_side                r_side [0:DIV_STEPS];

    logic [QW-1:0] w_ma;
    logic [QW-1:0] w_mb;

    assign w_ma = qmag(i_a);
    assign w_mb = qmag(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma[0]   <= w_ma;
            r_mb[0]   <= w_mb;
            r_neg[0]  <= i_a[QW-1] ^ i_b[QW-1];
            // A quotient of 2^47 or more saturates; a zero divisor lands here too.
            r_ovf[0]  <= {{DIV_PRE{1'b0}}, w_ma} >= {w_mb, {DIV_PRE{1'b0}}};
            r_rem[0]  <= w_ma >> DIV_PRE;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        localparam int BI = DIV_STEPS - 1 - g;
        logic          w_xb;
        logic [QW:0]   w_t;
        logic          w_ge;
        logic [QW:0]   w_d;

        if (BI >= FB) begin : g_bit
            assign w_xb = r_ma[g][BI-FB];
        end else begin : g_zero
            assign w_xb = 1'b0;
        end

        assign w_t  = {r_rem[g], w_xb};
        assign w_ge = w_t >= {1'b0, r_mb[g]};
        assign w_d  = w_t - {1'b0, r_mb[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ma[g+1]   <= r_ma[g];
                r_mb[g+1]   <= r_mb[g];
                r_neg[g+1]  <= r_neg[g];
                r_ovf[g+1]  <= r_ovf[g];
                r_rem[g+1]  <= w_ge ? w_d[QW-1:0] : w_t[QW-1:0];
                r_q[g+1]    <= {r_q[g][DIV_STEPS-2:0], w_ge};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    logic [QW-1:0] w_qu;
    assign w_qu = {1'b0, r_q[DIV_STEPS]};

    always_comb begin
        if (r_ovf[DIV_STEPS]) begin
            o_q = r_neg[DIV_STEPS] ? QMIN : QMAX;
        end else if (r_neg[DIV_STEPS]) begin
            o_q = -t_q'(w_qu);
        end else begin
            o_q = t_q'(w_qu);
        end
    end

    assign o_vld  = r_v[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];

endmodule

// ===== rtl/nfrc_step.sv =====
module nfrc_step
    import nfrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_cplx i_z,
    input  logic  i_flag,
    output logic  o_vld,
    output t_cplx o_z,
    output logic  o_flag
);

    // One Newton step: powers, p and p', Smith division, update.
    logic [8:0] r_v;

    t_cpp  r1_pp;
    t_cplx r1_z;
    logic  r1_f;

    t_cplx r2_z2, r2_z;
    logic  r2_f;

    t_cpp  r3_pa, r3_pb;
    t_cplx r3_z;
    logic  r3_f;

    t_cplx r4_z3, r4_z4, r4_z;
    logic  r4_f;

    t_cpp  r5_pa, r5_pb;
    t_cplx r5_z3, r5_z4, r5_z;
    logic  r5_f;

    t_cplx r6_z7, r6_z8, r6_z3, r6_z4, r6_z;
    logic  r6_f;

    t_cplx r7_t4, r7_z8, r7_d7, r7_d3, r7_z;
    logic  r7_f;

    t_cplx r8_p, r8_d, r8_z;
    logic  r8_f;

    t_side r9_side;
    t_q    r9_num, r9_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pp <= cmul_pp(i_z, i_z);
            r1_z  <= i_z;
            r1_f  <= i_flag;

            r2_z2 <= cmul_fin(r1_pp);
            r2_z  <= r1_z;
            r2_f  <= r1_f;

            r3_pa <= cmul_pp(r2_z2, r2_z);
            r3_pb <= cmul_pp(r2_z2, r2_z2);
            r3_z  <= r2_z;
            r3_f  <= r2_f;

            r4_z3 <= cmul_fin(r3_pa);
            r4_z4 <= cmul_fin(r3_pb);
            r4_z  <= r3_z;
            r4_f  <= r3_f;

            r5_pa <= cmul_pp(r4_z4, r4_z3);
            r5_pb <= cmul_pp(r4_z4, r4_z4);
            r5_z3 <= r4_z3;
            r5_z4 <= r4_z4;
            r5_z  <= r4_z;
            r5_f  <= r4_f;

            r6_z7 <= cmul_fin(r5_pa);
            r6_z8 <= cmul_fin(r5_pb);
            r6_z3 <= r5_z3;
            r6_z4 <= r5_z4;
            r6_z  <= r5_z;
            r6_f  <= r5_f;

            r7_t4 <= cscale(r6_z4, 4'd3);
            r7_d7 <= cscale(r6_z7, 4'd8);
            r7_d3 <= cscale(r6_z3, 4'd12);
            r7_z8 <= r6_z8;
            r7_z  <= r6_z;
            r7_f  <= r6_f;

            r8_p.re <= qsub(qadd(r7_z8.re, r7_t4.re), QFOUR);
            r8_p.im <= qadd(r7_z8.im, r7_t4.im);
            r8_d.re <= qadd(r7_d7.re, r7_d3.re);
            r8_d.im <= qadd(r7_d7.im, r7_d3.im);
            r8_z    <= r7_z;
            r8_f    <= r7_f;
        end
    end

    // Pick the branch of Smith's method and feed the ratio divider.
    logic w9_br;
    assign w9_br = qabs(r8_d.re) >= qabs(r8_d.im);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_side.z    <= r8_z;
            r9_side.p    <= r8_p;
            r9_side.d    <= r8_d;
            r9_side.br   <= w9_br;
            r9_side.dz   <= (r8_d.re == '0) && (r8_d.im == '0);
            r9_side.flag <= r8_f;
            r9_num       <= w9_br ? r8_d.im : r8_d.re;
            r9_dvs       <= w9_br ? r8_d.re : r8_d.im;
        end
    end

    logic  w_d1_v;
    t_q    w_d1_q;
    t_side w_d1_side;

    nfrc_div u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_v[8]),
        .i_a     (r9_num),
        .i_b     (r9_dvs),
        .i_side  (r9_side),
        .o_vld   (w_d1_v),
        .o_q     (w_d1_q),
        .o_side  (w_d1_side)
    );

    logic [2:0] r_vb;
    t_mpp  r10_pm, r10_ppi, r10_ppr;
    t_side r10_side, r11_side, r12_side;
    t_q    r11_m, r11_pi_r, r11_pr_r;
    t_q    r12_den, r12_nre, r12_nim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (i_en) begin
            r_vb <= {r_vb[1:0], w_d1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r10_pm   <= mul_pp(w_d1_side.br ? w_d1_side.d.im : w_d1_side.d.re, w_d1_q);
            r10_ppi  <= mul_pp(w_d1_side.p.im, w_d1_q);
            r10_ppr  <= mul_pp(w_d1_side.p.re, w_d1_q);
            r10_side <= w_d1_side;

            r11_m    <= mul_fin(r10_pm);
            r11_pi_r <= mul_fin(r10_ppi);
            r11_pr_r <= mul_fin(r10_ppr);
            r11_side <= r10_side;

            r12_side <= r11_side;
            if (r11_side.br) begin
                r12_den <= qadd(r11_side.d.re, r11_m);
                r12_nre <= qadd(r11_side.p.re, r11_pi_r);
                r12_nim <= qsub(r11_side.p.im, r11_pr_r);
            end else begin
                r12_den <= qadd(r11_side.d.im, r11_m);
                r12_nre <= qadd(r11_pr_r, r11_side.p.im);
                r12_nim <= qsub(r11_pi_r, r11_side.p.re);
            end
        end
    end

    logic  w_d2_v;
    t_q    w_qre, w_qim;
    t_side w_d2_side;

    nfrc_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_vb[2]),
        .i_a     (r12_nre),
        .i_b     (r12_den),
        .i_side  (r12_side),
        .o_vld   (w_d2_v),
        .o_q     (w_qre),
        .o_side  (w_d2_side)
    );

    nfrc_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_vb[2]),
        .i_a     (r12_nim),
        .i_b     (r12_den),
        .i_side  (r12_side),
        .o_vld   (),
        .o_q     (w_qim),
        .o_side  ()
    );

    logic  r13_v;
    t_cplx r13_z;
    logic  r13_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0;
        end else if (i_en) begin
            r13_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_d2_side.dz) begin
                r13_z <= w_d2_side.z;
            end else begin
                r13_z.re <= qsub(w_d2_side.z.re, w_qre);
                r13_z.im <= qsub(w_d2_side.z.im, w_qim);
            end
            r13_f <= w_d2_side.flag | w_d2_side.dz;
        end
    end

    assign o_vld  = r13_v;
    assign o_z    = r13_z;
    assign o_flag = r13_f;

endmodule

// ===== rtl/newton_fractal_root_classifier.sv =====
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_valid / o_ready         | i_data (t_in: c_re, c_im)
// result  | out       | o_valid / i_ready         | o_data (t_out: root_index, z_re,
//         |           |                           |   z_im, div_zero)
//
// While i_ready is high, one transaction enters per cycle and one result leaves
// per cycle once the pipe is full. Each Newton step passes through registers for
// powers and p', then the ratio divider, the Smith terms, the two quotient
// dividers and the update.
// Reset (synchronous, active low) clears only the valid bits along the pipe.
// When a result waits and i_ready is low, every stage holds; nothing is lost.
module newton_fractal_root_classifier
    import nfrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // The whole pipe advances unless the output register holds a result that
    // has not been taken. Bubbles travel like items, with their valid bit low.
    logic w_en;
    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    // Input stage: widen the Q4.28 start point into the internal Q16.32 format.
    logic  r0_v;
    t_cplx r0_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_z.re <= from_in(i_data.c_re);
            r0_z.im <= from_in(i_data.c_im);
        end
    end

    // Chain of Newton steps, each a full pipeline of its own.
    logic [ITERATIONS:0] w_v;
    logic [ITERATIONS:0] w_f;
    t_cplx               w_z [0:ITERATIONS];

    assign w_v[0] = r0_v;
    assign w_f[0] = 1'b0;
    assign w_z[0] = r0_z;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        nfrc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_v[g]),
            .i_z     (w_z[g]),
            .i_flag  (w_f[g]),
            .o_vld   (w_v[g+1]),
            .o_z     (w_z[g+1]),
            .o_flag  (w_f[g+1])
        );
    end

    // Classification: distance to each root, then a three-level minimum tree.
    // On equal distances the lower root index wins at every level.
    logic [5:0] r_cv;

    t_q                 r1_dr [NROOTS];
    t_q                 r1_di [NROOTS];
    logic signed [31:0] r1_ore, r1_oim;
    logic               r1_f;

    t_mpp               r2_pr [NROOTS];
    t_mpp               r2_pi [NROOTS];
    logic signed [31:0] r2_ore, r2_oim;
    logic               r2_f;

    t_q                 r3_dist [NROOTS];
    logic signed [31:0] r3_ore, r3_oim;
    logic               r3_f;

    t_q                 r4_dist [4];
    logic [2:0]         r4_idx  [4];
    logic signed [31:0] r4_ore, r4_oim;
    logic               r4_f;

    t_q                 r5_dist [2];
    logic [2:0]         r5_idx  [2];
    logic signed [31:0] r5_ore, r5_oim;
    logic               r5_f;

    t_out               r6_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (w_en) begin
            r_cv <= {r_cv[4:0], w_v[ITERATIONS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NROOTS; k++) begin
                r1_dr[k] <= qsub(w_z[ITERATIONS].re, ROOT_RE[k]);
                r1_di[k] <= qsub(w_z[ITERATIONS].im, ROOT_IM[k]);
                r2_pr[k] <= mul_pp(r1_dr[k], r1_dr[k]);
                r2_pi[k] <= mul_pp(r1_di[k], r1_di[k]);
                r3_dist[k] <= qadd(mul_fin(r2_pr[k]), mul_fin(r2_pi[k]));
            end
            r1_ore <= to_out(w_z[ITERATIONS].re);
            r1_oim <= to_out(w_z[ITERATIONS].im);
            r1_f   <= w_f[ITERATIONS];
            r2_ore <= r1_ore;
            r2_oim <= r1_oim;
            r2_f   <= r1_f;
            r3_ore <= r2_ore;
            r3_oim <= r2_oim;
            r3_f   <= r2_f;

            for (int k = 0; k < 4; k++) begin
                if (r3_dist[2*k+1] < r3_dist[2*k]) begin
                    r4_dist[k] <= r3_dist[2*k+1];
                    r4_idx[k]  <= 3'(2*k+1);
                end else begin
                    r4_dist[k] <= r3_dist[2*k];
                    r4_idx[k]  <= 3'(2*k);
                end
            end
            r4_ore <= r3_ore;
            r4_oim <= r3_oim;
            r4_f   <= r3_f;

            for (int k = 0; k < 2; k++) begin
                if (r4_dist[2*k+1] < r4_dist[2*k]) begin
                    r5_dist[k] <= r4_dist[2*k+1];
                    r5_idx[k]  <= r4_idx[2*k+1];
                end else begin
                    r5_dist[k] <= r4_dist[2*k];
                    r5_idx[k]  <= r4_idx[2*k];
                end
            end
            r5_ore <= r4_ore;
            r5_oim <= r4_oim;
            r5_f   <= r4_f;

            r6_out.root_index <= (r5_dist[1] < r5_dist[0]) ? r5_idx[1] : r5_idx[0];
            r6_out.z_re       <= r5_ore;
            r6_out.z_im       <= r5_oim;
            r6_out.div_zero   <= r5_f;
        end
    end

    assign o_valid = r_cv[5];
    assign o_data  = r6_out;

endmodule

// ===== tb/nfrc_checker.sv =====
module nfrc_checker
    import nfrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_ready,
    input  t_in  i_data,
    input  logic o_valid,
    input  logic i_ready,
    input  t_out o_data,
    output int   o_errors,
    output int   o_pending
);

    localparam logic signed [63:0] SMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = -64'sh0000_8000_0000_0000;

    t_out expected_q[$];

    function automatic logic signed [63:0] clip(input logic signed [127:0] v);
        if (v > 128'(SMAX)) return SMAX;
        if (v < 128'(SMIN)) return SMIN;
        return v[63:0];
    endfunction

    // Truncating product toward zero at 32 fraction bits.
    function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = m >> 32;
        return clip(p < 0 ? -$signed(m) : $signed(m));
    endfunction

    function automatic logic signed [63:0] fdiv(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        if (b == 0) return a < 0 ? SMIN : SMAX;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        q = (ma << 32) / mb;
        return clip(((a < 0) != (b < 0)) ? -$signed(q) : $signed(q));
    endfunction

    function automatic void cm(input logic signed [63:0] ar, ai, br, bi,
                               output logic signed [63:0] rr, ri);
        rr = clip(128'(fmul(ar, br)) - 128'(fmul(ai, bi)));
        ri = clip(128'(fmul(ar, bi)) + 128'(fmul(ai, br)));
    endfunction

    function automatic logic signed [31:0] narrow(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v >>> (32 - FRAC_BITS);
        if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (s < -64'sh8000_0000) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic t_out classify_point(input t_in c);
        logic signed [63:0] zr, zi, r2, i2, r3, i3, r4, i4, r7, i7, r8, i8;
        logic signed [63:0] pr, pi, dr, di, rt, den, qr, qi, sq_dist, best_dist, ddr, ddi;
        logic signed [63:0] one;
        t_out res;
        one = 64'sh1_0000_0000;
        zr = 64'(c.c_re) <<< (32 - FRAC_BITS);
        zi = 64'(c.c_im) <<< (32 - FRAC_BITS);
        res = '0;
        for (int it = 0; it < ITERATIONS; it++) begin
            cm(zr, zi, zr, zi, r2, i2);
            cm(r2, i2, zr, zi, r3, i3);
            cm(r2, i2, r2, i2, r4, i4);
            cm(r4, i4, r3, i3, r7, i7);
            cm(r4, i4, r4, i4, r8, i8);
            pr = clip(128'(clip(128'(r8) + 128'(fmul(r4, 3 * one)))) - 128'(4 * one));
            pi = clip(128'(i8) + 128'(fmul(i4, 3 * one)));
            dr = clip(128'(fmul(r7, 8 * one)) + 128'(fmul(r3, 12 * one)));
            di = clip(128'(fmul(i7, 8 * one)) + 128'(fmul(i3, 12 * one)));
            if (dr == 0 && di == 0) begin
                res.div_zero = 1'b1;
                continue;
            end
            if ((dr < 0 ? -dr : dr) >= (di < 0 ? -di : di)) begin
                rt = fdiv(di, dr);
                den = clip(128'(dr) + 128'(fmul(di, rt)));
                qr = fdiv(clip(128'(pr) + 128'(fmul(pi, rt))), den);
                qi = fdiv(clip(128'(pi) - 128'(fmul(pr, rt))), den);
            end else begin
                rt = fdiv(dr, di);
                den = clip(128'(di) + 128'(fmul(dr, rt)));
                qr = fdiv(clip(128'(fmul(pr, rt)) + 128'(pi)), den);
                qi = fdiv(clip(128'(fmul(pi, rt)) - 128'(pr)), den);
            end
            zr = clip(128'(zr) - 128'(qr));
            zi = clip(128'(zi) - 128'(qi));
        end
        best_dist = 0;
        for (int k = 0; k < NROOTS; k++) begin
            ddr = clip(128'(zr) - 128'(64'(ROOT_RE[k])));
            ddi = clip(128'(zi) - 128'(64'(ROOT_IM[k])));
            sq_dist = clip(128'(fmul(ddr, ddr)) + 128'(fmul(ddi, ddi)));
            if (k == 0 || sq_dist < best_dist) begin
                best_dist = sq_dist;
                res.root_index = 3'(k);
            end
        end
        res.z_re = narrow(zr);
        res.z_im = narrow(zi);
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.insert(expected_q.size(), classify_point(i_data));
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== o_data) begin
                        $display({"%0t: mismatch idx exp %0d act %0d, re exp %h act %h,",
                                  " im exp %h act %h, dz exp %b act %b"},
                                 $time, exp_r.root_index, o_data.root_index, exp_r.z_re,
                                 o_data.z_re, exp_r.z_im, o_data.z_im, exp_r.div_zero,
                                 o_data.div_zero);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_newton_fractal_root_classifier.sv =====
module tb_newton_fractal_root_classifier;
    import nfrc_pkg::*;

    // PIPE_DEPTH exceeds the depth of the pipe; the drain wait allows well beyond that.
    localparam int PIPE_DEPTH = 3300;
    localparam int RANDOM_POINTS = 1080;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    int   errors;
    int   pending;

    always #5 i_clk = ~i_clk;

    newton_fractal_root_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    nfrc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stall pattern: long open stretches alternate with phases of
    // random back-pressure.
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 20000) % 3;
        if (phase == 0) begin
            i_ready <= 1'b1;
        end else if (phase == 1) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= ($urandom_range(0, 1) != 0);
        end
    end

    // Presents one transaction and holds it until the block accepts it.
    task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
        i_valid <= 1'b1;
        i_data <= '{c_re: re, c_im: im};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // A random start point: mostly near the roots in Q4.28, sometimes full range.
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return 32'sh8000_0000 + $urandom_range(0, 15);
            3:       return 32'sh7FFF_FFF0 + $urandom_range(0, 15);
            4:       return $signed($urandom_range(0, 255)) - 128;
            default: return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        logic signed [31:0] dir_pts [0:19][0:1];
        dir_pts = '{
            '{32'sh0, 32'sh0}, '{32'sh1000_0000, 32'sh0}, '{-32'sh1000_0000, 32'sh0},
            '{32'sh0, 32'sh1000_0000}, '{32'sh0, -32'sh1000_0000},
            '{32'sh1000_0000, 32'sh1000_0000}, '{32'sh1000_0000, -32'sh1000_0000},
            '{-32'sh1000_0000, 32'sh1000_0000}, '{-32'sh1000_0000, -32'sh1000_0000},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, '{32'sh8000_0000, 32'sh8000_0000},
            '{32'sh7FFF_FFFF, 32'sh8000_0000}, '{32'sh8000_0000, 32'sh7FFF_FFFF},
            '{32'sh1, 32'sh0}, '{-32'sh1, -32'sh1},
            '{32'sh0800_0000, 32'sh0800_0000}, '{32'sh0B50_0000, 32'sh0},
            '{32'sh0800_0000, 32'sh0}, '{32'shFFFF_FFFF, 32'sh5555_5555},
            '{32'shAAAA_AAAA, 32'sh0000_0001}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed points: origin (zero derivative), each root, extremes, ties.
        foreach (dir_pts[k]) send_point(dir_pts[k][0], dir_pts[k][1]);
        idle_gap(1);
        // Let the pipe drain completely once before the random stream.
        while (pending != 0) @(posedge i_clk);
        sent = 0;
        while (sent < RANDOM_POINTS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_point(pick_coord(), pick_coord());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung pipe.
    initial begin
        #(64'd2_000_000 * 10);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
